### rtl/pcte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcte_pkg
// Shared types and constants of the parity counter threshold engine.
// ----------------------------------------------------------------------------
package pcte_pkg;

   localparam int COUNTER_BITS_DEF = 8;
   localparam int LANES_DEF        = 64;
   localparam int WORDS_DEF        = 512;

   localparam int FUNC_W       = 2;
   localparam int WORD_INDEX_W = 9;
   localparam int BITS_W       = 64;
   localparam int THRESHOLD_W  = 8;
   localparam int REM_W        = 22;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD  = 2'd0,
      FUNC_SUB  = 2'd1,
      FUNC_CLR  = 2'd2,
      FUNC_HOLD = 2'd3
   } func_type;

   typedef struct packed {
      logic     valid;
      func_type func;
   } pcte_ctl_type;

endpackage

### rtl/pcte_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcte_mem
// Counter store: one row per word, one write port and one registered read
// port.
// ----------------------------------------------------------------------------
module pcte_mem
   import pcte_pkg::*;
#(
   parameter int ROW_W  = COUNTER_BITS_DEF * LANES_DEF,
   parameter int DEPTH  = WORDS_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [ROW_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [ROW_W-1:0]  rd_data
);

   logic [ROW_W-1:0] mem_array [DEPTH];
   logic [ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_array[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/pcte_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcte_update
// Lane arithmetic: add, subtract threshold, clear or hold each counter of a
// row, and extract the sign plane.
// ----------------------------------------------------------------------------
module pcte_update
   import pcte_pkg::*;
#(
   parameter int COUNTER_BITS = COUNTER_BITS_DEF,
   parameter int LANES        = LANES_DEF
) (
   input  pcte_ctl_type                    ctl,
   input  logic [COUNTER_BITS*LANES-1:0]   old_row,
   input  logic [BITS_W-1:0]               bits,
   input  logic [THRESHOLD_W-1:0]          threshold,
   output logic [COUNTER_BITS*LANES-1:0]   new_row,
   output logic [BITS_W-1:0]               sign_bits
);

   logic [15:0]             thr_wide;
   logic [COUNTER_BITS-1:0] thr_cnt;

   assign thr_wide = {{(16-THRESHOLD_W){1'b0}}, threshold};
   assign thr_cnt  = thr_wide[COUNTER_BITS-1:0];

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      logic                    lane_bit;
      logic [COUNTER_BITS-1:0] old_cnt;
      logic [COUNTER_BITS-1:0] new_cnt;

      if (k < BITS_W) begin : g_in
         assign lane_bit = bits[k];
      end else begin : g_noin
         assign lane_bit = 1'b0;
      end

      assign old_cnt = old_row[k*COUNTER_BITS +: COUNTER_BITS];

      always_comb begin
         case (ctl.func)
            FUNC_ADD: new_cnt = old_cnt + {{(COUNTER_BITS-1){1'b0}}, lane_bit};
            FUNC_SUB: new_cnt = old_cnt - thr_cnt;
            FUNC_CLR: new_cnt = '0;
            default:  new_cnt = old_cnt;
         endcase
      end

      assign new_row[k*COUNTER_BITS +: COUNTER_BITS] = new_cnt;
   end

   for (genvar k = 0; k < BITS_W; k++) begin : g_sign
      if (k < LANES) begin : g_live
         assign sign_bits[k] = new_row[k*COUNTER_BITS + COUNTER_BITS - 1];
      end else begin : g_dead
         assign sign_bits[k] = 1'b0;
      end
   end

endmodule

### rtl/parity_counter_threshold_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parity_counter_threshold_engine
// Per-position counter store with add, subtract-threshold, clear and hold per word.
// ----------------------------------------------------------------------------
// After reset the engine holds busy while it zeroes all WORDS rows (512 by
// default) of the counter memory one row per cycle. From then on it takes
// one command per cycle and never raises busy again. Each command's row
// arrives from the counter memory in the cycle after the transfer and is
// updated and written back at the end of that cycle; the sign plane is then
// registered and shows on rsp_sign_bits with rsp_strobe for one cycle.
// Back-to-back commands on the same word are served by forwarding the row
// just written. The result is present for one cycle only; the receiver must
// take it then. Write the threshold only while no command is in flight.
// ----------------------------------------------------------------------------
module parity_counter_threshold_engine
   import pcte_pkg::*;
#(
   parameter int COUNTER_BITS = COUNTER_BITS_DEF,
   parameter int LANES        = LANES_DEF,
   parameter int WORDS        = WORDS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [FUNC_W-1:0]       req_func,
   input  logic [WORD_INDEX_W-1:0] req_word_index,
   input  logic [BITS_W-1:0]       req_bits,
   output logic                    rsp_strobe,
   output logic [BITS_W-1:0]       rsp_sign_bits,
   input  logic                    csr_we,
   input  logic [THRESHOLD_W-1:0]  csr_wdata
);

   localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int ROW_W = COUNTER_BITS * LANES;

   logic                   accept;
   logic [REM_W-1:0]       word_rem;
   logic [IDX_W-1:0]       rd_addr;

   logic                   clr_active_ff, clr_active_in;
   logic [IDX_W-1:0]       clr_ptr_ff, clr_ptr_in;
   logic [THRESHOLD_W-1:0] threshold_ff, threshold_in;

   pcte_ctl_type           st_ctl_ff, st_ctl_in;
   logic [IDX_W-1:0]       st_word_ff;
   logic [BITS_W-1:0]      st_bits_ff;

   logic                   fw_valid_ff, fw_valid_in;
   logic [IDX_W-1:0]       fw_word_ff;
   logic [ROW_W-1:0]       fw_row_ff;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [BITS_W-1:0]      rsp_sign_bits_ff;

   logic [ROW_W-1:0]       mem_rd_data;
   logic [ROW_W-1:0]       old_row;
   logic [ROW_W-1:0]       new_row;
   logic [BITS_W-1:0]      sign_bits;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [ROW_W-1:0]       wr_data;

   assign busy   = clr_active_ff;
   assign accept = start && !clr_active_ff;

   // reduce the word index modulo WORDS by restoring subtraction
   always_comb begin
      word_rem = REM_W'(req_word_index);
      for (int s = WORD_INDEX_W - 1; s >= 0; s--) begin
         if (word_rem >= (REM_W'(WORDS) << s)) begin
            word_rem = word_rem - (REM_W'(WORDS) << s);
         end
      end
   end

   assign rd_addr = word_rem[IDX_W-1:0];

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_ptr_in    = clr_ptr_ff;
      if (clr_active_ff) begin
         clr_ptr_in = clr_ptr_ff + 1'b1;
         if (clr_ptr_ff == IDX_W'(WORDS - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   assign threshold_in    = csr_we ? csr_wdata : threshold_ff;
   assign st_ctl_in.valid = accept;
   assign st_ctl_in.func  = func_type'(req_func);
   assign fw_valid_in     = st_ctl_ff.valid;
   assign rsp_strobe_in   = st_ctl_ff.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_ptr_ff    <= '0;
         threshold_ff  <= '0;
         st_ctl_ff     <= '{valid: 1'b0, func: FUNC_HOLD};
         fw_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_ptr_ff    <= clr_ptr_in;
         threshold_ff  <= threshold_in;
         st_ctl_ff     <= st_ctl_in;
         fw_valid_ff   <= fw_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      st_word_ff       <= rd_addr;
      st_bits_ff       <= req_bits;
      fw_word_ff       <= st_word_ff;
      fw_row_ff        <= new_row;
      rsp_sign_bits_ff <= sign_bits;
   end

   // forward the row written last cycle; the memory read saw the old value
   assign old_row = (fw_valid_ff && (fw_word_ff == st_word_ff)) ? fw_row_ff : mem_rd_data;

   assign wr_en   = clr_active_ff || st_ctl_ff.valid;
   assign wr_addr = clr_active_ff ? clr_ptr_ff : st_word_ff;
   assign wr_data = clr_active_ff ? '0 : new_row;

   pcte_mem #(
      .ROW_W  (ROW_W),
      .DEPTH  (WORDS),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (mem_rd_data)
   );

   pcte_update #(
      .COUNTER_BITS (COUNTER_BITS),
      .LANES        (LANES)
   ) u_update (
      .ctl       (st_ctl_ff),
      .old_row   (old_row),
      .bits      (st_bits_ff),
      .threshold (threshold_ff),
      .new_row   (new_row),
      .sign_bits (sign_bits)
   );

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_sign_bits = rsp_sign_bits_ff;

endmodule

### rtl/pcte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcte_checker
// Port-level checks of the parity counter threshold engine, bound to the top.
// ----------------------------------------------------------------------------
module pcte_checker
   import pcte_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic [FUNC_W-1:0]       req_func,
   input logic                    rsp_strobe,
   input logic [BITS_W-1:0]       rsp_sign_bits
);

   logic xfer;

   assign xfer = start && !busy && !reset;

   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy not raised after reset");

   a_busy_stays_low: assert property (@(posedge clock) disable iff (reset)
      !busy |=> !busy)
      else $error("busy raised outside reset");

   a_xfer_answered: assert property (@(posedge clock) disable iff (reset)
      xfer |=> ##1 rsp_strobe)
      else $error("transfer without result");

   a_result_caused: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(xfer, 2))
      else $error("result without transfer");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (xfer && (req_func == FUNC_CLR)) |=> ##1 (rsp_sign_bits == '0))
      else $error("clear returned nonzero sign plane");

endmodule

bind parity_counter_threshold_engine pcte_checker u_pcte_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_func      (req_func),
   .rsp_strobe    (rsp_strobe),
   .rsp_sign_bits (rsp_sign_bits)
);

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the parity counter threshold engine.
// ----------------------------------------------------------------------------
// A queue of commands feeds a falling-edge driver. A rising-edge monitor keeps
// a private copy of the per-lane counter store and of the threshold, predicts
// the sign plane of every accepted transfer and checks each strobed result in
// order. A short directed part walks every function, wrap in both directions
// and the threshold extremes. A random part follows that concentrates on a
// few hot words so that counters climb past the sign bit, with the threshold
// changed between phases and the sender gap rate varied.
// ----------------------------------------------------------------------------
module tb;
   import pcte_pkg::*;

   localparam int LANE_CNT     = 64;
   localparam int WORD_CNT     = 512;
   localparam int CHUNK_ITEMS  = 255;
   localparam int LIMIT_CYCLES = 60000;

   typedef struct {
      func_type                op;
      logic [WORD_INDEX_W-1:0] word;
      logic [BITS_W-1:0]       bits;
   } word_cmd_type;

   logic                    clock;
   logic                    reset          = 1'b1;
   logic                    start          = 1'b0;
   logic                    busy;
   logic [FUNC_W-1:0]       req_func       = '0;
   logic [WORD_INDEX_W-1:0] req_word_index = '0;
   logic [BITS_W-1:0]       req_bits       = '0;
   logic                    rsp_strobe;
   logic [BITS_W-1:0]       rsp_sign_bits;
   logic                    csr_we         = 1'b0;
   logic [THRESHOLD_W-1:0]  csr_wdata      = '0;

   word_cmd_type            cmd_q[$];
   logic [BITS_W-1:0]       sign_plane_q[$];
   logic [7:0]              cnt_mem [0:WORD_CNT-1][0:LANE_CNT-1];
   logic [THRESHOLD_W-1:0]  thr_model = '0;
   logic [BITS_W-1:0]       want_plane;
   word_cmd_type            nxt_cmd;
   logic                    took = 1'b0;
   int                      send_gap_pct = 0;
   int                      cycle_cnt = 0;
   int                      err_cnt = 0;
   int                      op_cnt [4] = '{0, 0, 0, 0};
   int                      rsp_cnt = 0;
   int                      sign_ones = 0;
   int                      thr_writes = 0;

   parity_counter_threshold_engine dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_word_index (req_word_index),
      .req_bits       (req_bits),
      .rsp_strobe     (rsp_strobe),
      .rsp_sign_bits  (rsp_sign_bits),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic logic [BITS_W-1:0] apply_word_op(func_type op,
                                                        logic [WORD_INDEX_W-1:0] w,
                                                        logic [BITS_W-1:0] b);
      logic [7:0]        c;
      logic [BITS_W-1:0] plane;
      plane = '0;
      for (int k = 0; k < LANE_CNT; k++) begin
         c = cnt_mem[w][k];
         case (op)
            FUNC_ADD: c = c + 8'(b[k]);
            FUNC_SUB: c = c - thr_model;
            FUNC_CLR: c = '0;
            default: ;
         endcase
         cnt_mem[w][k] = c;
         plane[k] = c[7];
      end
      return plane;
   endfunction

   // driver: hold the current command until it transfers
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && !took)) begin
         if (cmd_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            nxt_cmd = cmd_q.pop_front();
            start          <= 1'b1;
            req_func       <= nxt_cmd.op;
            req_word_index <= nxt_cmd.word;
            req_bits       <= nxt_cmd.bits;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check strobed results, predict accepted transfers
   always @(posedge clock) begin
      cycle_cnt++;
      took = 1'b0;
      if (!reset) begin
         if (csr_we) begin
            thr_model = csr_wdata;
         end
         if (rsp_strobe === 1'b1) begin
            rsp_cnt++;
            if (sign_plane_q.size() == 0) begin
               $error("sign_bits: result with no transfer pending, actual %h", rsp_sign_bits);
               err_cnt++;
            end else begin
               want_plane = sign_plane_q.pop_front();
               sign_ones += $countones(want_plane);
               if (rsp_sign_bits !== want_plane) begin
                  $error("sign_bits mismatch: expected %h, actual %h", want_plane,
                         rsp_sign_bits);
                  err_cnt++;
               end
            end
         end
         if (start && busy === 1'b0) begin
            took = 1'b1;
            op_cnt[req_func]++;
            sign_plane_q.push_back(apply_word_op(func_type'(req_func), req_word_index,
                                                 req_bits));
         end
      end
      if (cycle_cnt >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_cnt);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic push_cmd(func_type op, logic [WORD_INDEX_W-1:0] w, logic [BITS_W-1:0] b);
      word_cmd_type c;
      c.op   = op;
      c.word = w;
      c.bits = b;
      cmd_q.push_back(c);
   endtask

   task automatic drain();
      while (cmd_q.size() != 0 || start || sign_plane_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(logic [THRESHOLD_W-1:0] v);
      drain();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      thr_writes++;
   endtask

   task automatic queue_random_cmds(int n);
      word_cmd_type c;
      int           r;
      int           hot;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 62) begin
            c.op = FUNC_ADD;
         end else if (r < 82) begin
            c.op = FUNC_SUB;
         end else if (r < 87) begin
            c.op = FUNC_CLR;
         end else if (r < 93) begin
            c.op = FUNC_HOLD;
         end else begin
            c.op = FUNC_ADD;
         end
         // keep most traffic on a few words so counters reach the sign bit
         if ($urandom_range(99) < 70) begin
            hot    = $urandom_range(3);
            c.word = (hot == 3) ? 9'd511 : 9'(hot * 85);
         end else begin
            c.word = WORD_INDEX_W'($urandom_range(WORD_CNT - 1));
         end
         case ($urandom_range(3))
            0: c.bits = {$urandom, $urandom};
            1: c.bits = '1;
            2: c.bits = 64'd1 << $urandom_range(63);
            default: c.bits = {$urandom, $urandom} | {$urandom, $urandom};
         endcase
         cmd_q.push_back(c);
      end
   endtask

   initial begin
      for (int w = 0; w < WORD_CNT; w++) begin
         for (int k = 0; k < LANE_CNT; k++) begin
            cnt_mem[w][k] = '0;
         end
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset threshold of zero
      push_cmd(FUNC_HOLD, 9'd0, '1);
      push_cmd(FUNC_ADD, 9'd0, '1);
      push_cmd(FUNC_SUB, 9'd0, '0);
      push_cmd(FUNC_CLR, 9'd0, '1);
      push_cmd(FUNC_ADD, 9'd511, '0);
      push_cmd(FUNC_ADD, 9'd511, 64'h8000_0000_0000_0001);
      push_cmd(FUNC_SUB, 9'd511, '1);
      push_cmd(FUNC_HOLD, 9'd511, '0);
      // underflow wraps every lane to all ones
      write_threshold(8'd1);
      push_cmd(FUNC_SUB, 9'd3, '0);
      push_cmd(FUNC_ADD, 9'd3, '1);
      push_cmd(FUNC_SUB, 9'd3, 64'h5555_5555_5555_5555);
      push_cmd(FUNC_ADD, 9'd3, 64'hAAAA_AAAA_AAAA_AAAA);
      push_cmd(FUNC_HOLD, 9'd3, '1);
      write_threshold(8'd255);
      push_cmd(FUNC_SUB, 9'd3, '0);
      push_cmd(FUNC_SUB, 9'd3, '0);
      push_cmd(FUNC_HOLD, 9'd256, '0);
      write_threshold(8'd128);
      push_cmd(FUNC_SUB, 9'd3, '0);
      push_cmd(FUNC_ADD, 9'd3, 64'hFFFF_FFFF_0000_0000);
      push_cmd(FUNC_SUB, 9'd3, '0);
      push_cmd(FUNC_CLR, 9'd3, '0);
      push_cmd(FUNC_HOLD, 9'd3, '0);
      drain();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: write_threshold(8'd255);
            1: write_threshold(8'($urandom_range(2, 126)));
            2: write_threshold(8'd0);
            3: write_threshold(8'd127);
            4: write_threshold(8'($urandom_range(129, 254)));
            default: write_threshold(8'd1);
         endcase
         send_gap_pct = (p < 2) ? 8 : (p < 4) ? 49 : 0;
         queue_random_cmds(CHUNK_ITEMS);
         drain();
      end

      repeat (8) @(posedge clock);
      $display("covered: %0d add, %0d subtract, %0d clear, %0d hold transfers, %0d results",
               op_cnt[FUNC_ADD], op_cnt[FUNC_SUB], op_cnt[FUNC_CLR], op_cnt[FUNC_HOLD],
               rsp_cnt);
      $display("covered: %0d threshold writes, %0d sign bits set, %0d mismatches",
               thr_writes, sign_ones, err_cnt);
      if (err_cnt == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/pcte_pkg.sv
rtl/pcte_mem.sv
rtl/pcte_update.sv
rtl/parity_counter_threshold_engine.sv
rtl/pcte_checker.sv
verif/tb.sv
